[hw/rtl/rtlsd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtlsd_pkg
// Shared widths, reset values, register indexes, control types and the
// least-squares denominator table of the trajectory differentiator.
// ----------------------------------------------------------------------------
package rtlsd_pkg;

    localparam int DATA_W         = 32;
    localparam int JOY_W          = 16;
    localparam int JOY_FRAC       = 15;
    localparam int SCALE_W        = 25;
    localparam int SCALE_FRAC     = 24;
    localparam int CFG_IDX_W      = 2;
    localparam int WINDOW_DEFAULT = 10;

    // Clamped slope magnitude is at most 2^33, so it fits in 34 bits.
    localparam int QUOT_W = 34;
    localparam int STEP_W = $clog2(QUOT_W);

    localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_OFFSET = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_SPAN   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOPE_SCALE  = 2'd2;

    localparam logic signed [DATA_W-1:0] ANGLE_OFFSET_RST = 32'sd52707179;
    localparam logic signed [DATA_W-1:0] ANGLE_SPAN_RST   = 32'sd39530384;
    localparam logic [SCALE_W-1:0]       SLOPE_SCALE_RST  = 25'd16777;

    typedef struct packed {
        logic clear;
        logic acc;
        logic finish;
    } slope_ctl_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_WAIT
    } ctrl_state_t;

    typedef enum logic [3:0] {
        SL_IDLE,
        SL_PROD,
        SL_DIFF,
        SL_ABS,
        SL_ROUND,
        SL_CHECK,
        SL_DIV,
        SL_MLO,
        SL_MHI,
        SL_FIN
    } slope_state_t;

    // n^2 (n^2 - 1) / 12, the denominator n*Sxx - Sx*Sx for sample indexes 0..n-1.
    function automatic logic [16:0] den_of(input logic [5:0] n);
        logic [16:0] d;
        case (n)
            6'd2:    d = 17'd1;
            6'd3:    d = 17'd6;
            6'd4:    d = 17'd20;
            6'd5:    d = 17'd50;
            6'd6:    d = 17'd105;
            6'd7:    d = 17'd196;
            6'd8:    d = 17'd336;
            6'd9:    d = 17'd540;
            6'd10:   d = 17'd825;
            6'd11:   d = 17'd1210;
            6'd12:   d = 17'd1716;
            6'd13:   d = 17'd2366;
            6'd14:   d = 17'd3185;
            6'd15:   d = 17'd4200;
            6'd16:   d = 17'd5440;
            6'd17:   d = 17'd6936;
            6'd18:   d = 17'd8721;
            6'd19:   d = 17'd10830;
            6'd20:   d = 17'd13300;
            6'd21:   d = 17'd16170;
            6'd22:   d = 17'd19481;
            6'd23:   d = 17'd23276;
            6'd24:   d = 17'd27600;
            6'd25:   d = 17'd32500;
            6'd26:   d = 17'd38025;
            6'd27:   d = 17'd44226;
            6'd28:   d = 17'd51156;
            6'd29:   d = 17'd58870;
            6'd30:   d = 17'd67425;
            6'd31:   d = 17'd76880;
            6'd32:   d = 17'd87296;
            default: d = 17'd0;
        endcase
        return d;
    endfunction

endpackage

[hw/rtl/rtlsd_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtlsd_cell
// One sample slot of a window chain; takes its neighbor's sample on a shift.
// ----------------------------------------------------------------------------
module rtlsd_cell #(
    parameter int WIDTH = rtlsd_pkg::DATA_W
) (
    input  logic             clk,
    input  logic             shift_en,
    input  logic [WIDTH-1:0] d,
    output logic [WIDTH-1:0] q
);

    logic [WIDTH-1:0] sample_reg;
    logic [WIDTH-1:0] sample_next;

    always_comb
    begin
        sample_next = shift_en ? d : sample_reg;
    end

    always_ff @(posedge clk)
    begin
        sample_reg <= sample_next;
    end

    assign q = sample_reg;

endmodule

[hw/rtl/rtlsd_slope.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtlsd_slope
// Accumulates the sums of one window as its chain rotates past, then forms
// the least-squares slope with a bit-serial divider and scales it.
// ----------------------------------------------------------------------------
module rtlsd_slope #(
    parameter int WINDOW = rtlsd_pkg::WINDOW_DEFAULT,
    localparam int NW    = $clog2(WINDOW + 1),
    localparam int AGW   = $clog2(WINDOW)
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  rtlsd_pkg::slope_ctl_t                  ctl,
    input  logic [AGW-1:0]                         age,
    input  logic [NW-1:0]                          count,
    input  logic signed [rtlsd_pkg::DATA_W-1:0]    sample,
    input  logic [rtlsd_pkg::SCALE_W-1:0]          scale,
    output logic                                   done,
    output logic signed [rtlsd_pkg::DATA_W-1:0]    slope
);

    localparam int DW      = rtlsd_pkg::DATA_W;
    localparam int QW      = rtlsd_pkg::QUOT_W;
    localparam int HW      = QW / 2;
    localparam int SW      = rtlsd_pkg::SCALE_W;
    localparam int TRI_MAX = WINDOW * (WINDOW - 1) / 2;
    localparam int TRI_W   = $clog2(TRI_MAX + 1);
    localparam int SY_W    = DW + $clog2(WINDOW);
    localparam int SA_W    = DW + TRI_W;
    localparam int NUM_W   = DW + 1 + $clog2(WINDOW * TRI_MAX + 1);
    localparam int DEN_W   = $clog2(WINDOW * WINDOW * (WINDOW * WINDOW - 1) / 12 + 1);
    localparam int CMP_W   = (NUM_W > DEN_W + QW) ? NUM_W : DEN_W + QW;
    localparam int ACC_W   = QW + SW - 1;
    localparam int RW      = ACC_W - rtlsd_pkg::SCALE_FRAC;

    localparam logic [RW-1:0] NEG_LIM = RW'(1) << (DW - 1);
    localparam logic [RW-1:0] POS_LIM = NEG_LIM - 1'b1;
    localparam logic [QW-1:0] Q_CLAMP = QW'(1) << (QW - 1);

    rtlsd_pkg::slope_state_t state_reg, state_next;

    logic signed [SY_W-1:0]  sy_reg, sy_next;
    logic signed [SA_W-1:0]  say_reg, say_next;
    logic signed [NUM_W-1:0] pa_reg, pa_next;
    logic signed [NUM_W-1:0] pb_reg, pb_next;
    logic signed [NUM_W-1:0] num_reg, num_next;
    logic [NUM_W-1:0]        mag_reg, mag_next;
    logic [NUM_W-1:0]        dvd_reg, dvd_next;
    logic [CMP_W-1:0]        lim_reg, lim_next;
    logic [DEN_W-1:0]        den_reg, den_next;
    logic [DEN_W-1:0]        rem_reg, rem_next;
    logic [QW-1:0]           q_reg, q_next;
    logic                    neg_reg, neg_next;
    logic                    clamp_reg, clamp_next;
    logic [rtlsd_pkg::STEP_W-1:0] step_reg, step_next;
    logic [ACC_W-1:0]        acc_reg, acc_next;
    logic signed [DW-1:0]    slope_reg, slope_next;
    logic                    done_reg, done_next;

    logic signed [AGW+DW:0]      age_prod;
    logic [2*NW-1:0]             nn;
    logic [TRI_W-1:0]            tri_w;
    logic signed [TRI_W+SY_W:0]  pa_full;
    logic signed [NW+SA_W:0]     pb_full;
    logic [DEN_W:0]              trial;
    logic                        ge;
    logic [QW-1:0]               qsel;
    logic [HW+SW-1:0]            mlo;
    logic [QW-HW+SW-1:0]         mhi;
    logic [ACC_W-1:0]            rsum;
    logic [RW-1:0]               rnd;

    always_comb
    begin
        age_prod = $signed({1'b0, age}) * sample;
        nn       = (2 * NW)'(count) * (2 * NW)'(count - 1'b1);
        tri_w    = TRI_W'(nn >> 1);
        pa_full  = $signed({1'b0, tri_w}) * sy_reg;
        pb_full  = $signed({1'b0, count}) * say_reg;
        trial    = {rem_reg, q_reg[QW-1]};
        ge       = (trial >= {1'b0, den_reg});
        qsel     = clamp_reg ? Q_CLAMP : q_reg;
        mlo      = qsel[HW-1:0] * scale;
        mhi      = qsel[QW-1:HW] * scale;
        rsum     = acc_reg + (ACC_W'(1) << (rtlsd_pkg::SCALE_FRAC - 1));
        rnd      = rsum[ACC_W-1:rtlsd_pkg::SCALE_FRAC];
    end

    always_comb
    begin
        state_next = state_reg;
        sy_next    = sy_reg;
        say_next   = say_reg;
        pa_next    = pa_reg;
        pb_next    = pb_reg;
        num_next   = num_reg;
        mag_next   = mag_reg;
        dvd_next   = dvd_reg;
        lim_next   = lim_reg;
        den_next   = den_reg;
        rem_next   = rem_reg;
        q_next     = q_reg;
        neg_next   = neg_reg;
        clamp_next = clamp_reg;
        step_next  = step_reg;
        acc_next   = acc_reg;
        slope_next = slope_reg;
        done_next  = done_reg;

        // The sums see the chain tail while it rotates; samples older than
        // the fill count are stale and are skipped.
        if (ctl.clear)
        begin
            sy_next   = '0;
            say_next  = '0;
            done_next = 1'b0;
        end
        else if (ctl.acc && (NW'(age) < count))
        begin
            sy_next  = sy_reg + SY_W'(sample);
            say_next = say_reg + SA_W'(age_prod);
        end

        case (state_reg)
            rtlsd_pkg::SL_IDLE:
            begin
                if (ctl.finish)
                begin
                    state_next = rtlsd_pkg::SL_PROD;
                end
            end
            rtlsd_pkg::SL_PROD:
            begin
                pa_next    = NUM_W'(pa_full);
                pb_next    = NUM_W'(pb_full);
                den_next   = DEN_W'(rtlsd_pkg::den_of(6'(count)));
                state_next = rtlsd_pkg::SL_DIFF;
            end
            rtlsd_pkg::SL_DIFF:
            begin
                num_next   = pa_reg - pb_reg;
                state_next = rtlsd_pkg::SL_ABS;
            end
            rtlsd_pkg::SL_ABS:
            begin
                neg_next   = num_reg[NUM_W-1];
                mag_next   = num_reg[NUM_W-1] ? $unsigned(-num_reg) : $unsigned(num_reg);
                state_next = rtlsd_pkg::SL_ROUND;
            end
            rtlsd_pkg::SL_ROUND:
            begin
                dvd_next   = mag_reg + NUM_W'(den_reg >> 1);
                lim_next   = (CMP_W'(den_reg) << (QW - 1)) + CMP_W'(den_reg);
                state_next = rtlsd_pkg::SL_CHECK;
            end
            rtlsd_pkg::SL_CHECK:
            begin
                // A quotient above 2^33 is clamped, so only QW quotient bits
                // are ever developed.
                clamp_next = (CMP_W'(dvd_reg) >= lim_reg);
                rem_next   = DEN_W'(dvd_reg >> QW);
                q_next     = QW'(dvd_reg);
                step_next  = rtlsd_pkg::STEP_W'(QW - 1);
                state_next = rtlsd_pkg::SL_DIV;
            end
            rtlsd_pkg::SL_DIV:
            begin
                rem_next = ge ? DEN_W'(trial - {1'b0, den_reg}) : DEN_W'(trial);
                q_next   = {q_reg[QW-2:0], ge};
                step_next = step_reg - 1'b1;
                if (step_reg == '0)
                begin
                    state_next = rtlsd_pkg::SL_MLO;
                end
            end
            rtlsd_pkg::SL_MLO:
            begin
                acc_next   = ACC_W'(mlo);
                state_next = rtlsd_pkg::SL_MHI;
            end
            rtlsd_pkg::SL_MHI:
            begin
                acc_next   = acc_reg + (ACC_W'(mhi) << HW);
                state_next = rtlsd_pkg::SL_FIN;
            end
            rtlsd_pkg::SL_FIN:
            begin
                if (den_reg == '0)
                begin
                    slope_next = '0;
                end
                else if (!neg_reg)
                begin
                    slope_next = (rnd > POS_LIM) ? DW'(POS_LIM) : DW'(rnd);
                end
                else
                begin
                    slope_next = (rnd > NEG_LIM) ? DW'(NEG_LIM) : DW'(~rnd + 1'b1);
                end
                done_next  = 1'b1;
                state_next = rtlsd_pkg::SL_IDLE;
            end
            default:
            begin
                state_next = rtlsd_pkg::SL_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rtlsd_pkg::SL_IDLE;
            done_reg  <= 1'b0;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            step_reg  <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sy_reg    <= sy_next;
        say_reg   <= say_next;
        pa_reg    <= pa_next;
        pb_reg    <= pb_next;
        num_reg   <= num_next;
        mag_reg   <= mag_next;
        dvd_reg   <= dvd_next;
        lim_reg   <= lim_next;
        den_reg   <= den_next;
        rem_reg   <= rem_next;
        q_reg     <= q_next;
        neg_reg   <= neg_next;
        clamp_reg <= clamp_next;
        acc_reg   <= acc_next;
        slope_reg <= slope_next;
    end

    assign done  = done_reg;
    assign slope = slope_reg;

endmodule

[hw/rtl/reference_trajectory_ls_differentiator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// reference_trajectory_ls_differentiator
// Joystick to target angle, with velocity and acceleration taken as scaled
// least-squares slopes over sliding windows held in chains of cells.
// ----------------------------------------------------------------------------
// An accepted word is followed by one rotation of the window chains, then the
// slope units develop 34 quotient bits in a bit-serial divider and scale the
//   result before out_valid rises; the input stalls until the word is finished.
// A finished word waits in the output register while the next one is taken.
// Reset clears the fill count, the previous outputs and the control state,
//   and loads the register defaults; window cells are not cleared.
// ----------------------------------------------------------------------------
module reference_trajectory_ls_differentiator #(
    parameter int WINDOW = rtlsd_pkg::WINDOW_DEFAULT
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     cfg_wr_en,
    input  logic [rtlsd_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [rtlsd_pkg::DATA_W-1:0]             cfg_data,
    input  logic                                     in_valid,
    output logic                                     in_stall,
    input  logic signed [rtlsd_pkg::JOY_W-1:0]       joystick_y,
    input  logic                                     hold,
    output logic                                     out_valid,
    input  logic                                     out_stall,
    output logic signed [rtlsd_pkg::DATA_W-1:0]      traj_angle,
    output logic signed [rtlsd_pkg::DATA_W-1:0]      traj_velocity,
    output logic signed [rtlsd_pkg::DATA_W-1:0]      traj_accel
);

    localparam int DW  = rtlsd_pkg::DATA_W;
    localparam int NW  = $clog2(WINDOW + 1);
    localparam int AGW = $clog2(WINDOW);
    localparam int PW  = rtlsd_pkg::JOY_W + DW;
    localparam int RDW = PW - rtlsd_pkg::JOY_FRAC;
    localparam int SUMW = DW + 2;

    localparam logic signed [SUMW-1:0] SAT_HI = 34'sh0_7FFF_FFFF;
    localparam logic signed [SUMW-1:0] SAT_LO = 34'sh3_8000_0000;
    localparam logic signed [PW-1:0]   HALF   = PW'(1) << (rtlsd_pkg::JOY_FRAC - 1);

    function automatic logic signed [DW-1:0] sat32(input logic signed [SUMW-1:0] v);
        logic signed [DW-1:0] r;
        if (v > SAT_HI)
        begin
            r = SAT_HI[DW-1:0];
        end
        else if (v < SAT_LO)
        begin
            r = SAT_LO[DW-1:0];
        end
        else
        begin
            r = v[DW-1:0];
        end
        return r;
    endfunction

    rtlsd_pkg::ctrl_state_t state_reg, state_next;

    logic signed [DW-1:0]              offset_reg, offset_next;
    logic signed [DW-1:0]              span_reg, span_next;
    logic [rtlsd_pkg::SCALE_W-1:0]     scale_reg, scale_next;
    logic [NW-1:0]                     fill_reg, fill_next;
    logic [AGW-1:0]                    scan_reg, scan_next;
    logic signed [DW-1:0]              last_angle_reg, last_angle_next;
    logic signed [DW-1:0]              last_vel_reg, last_vel_next;
    logic                              out_valid_reg, out_valid_next;

    logic signed [rtlsd_pkg::JOY_W-1:0] joy_reg, joy_next;
    logic                              hold_reg, hold_next;
    logic signed [PW-1:0]              prod_reg, prod_next;
    logic signed [RDW-1:0]             rnd_reg, rnd_next;
    logic signed [DW-1:0]              angle_calc_reg, angle_calc_next;
    logic signed [DW-1:0]              out_angle_reg, out_angle_next;
    logic signed [DW-1:0]              out_vel_reg, out_vel_next;
    logic signed [DW-1:0]              out_acc_reg, out_acc_next;

    logic                  accept;
    logic                  scanning;
    logic                  shift_en;
    logic                  out_load;
    logic signed [PW-1:0]  rsum;
    logic signed [SUMW-1:0] asum;
    rtlsd_pkg::slope_ctl_t ctl;

    logic [DW-1:0]         ang_q [WINDOW];
    logic [DW-1:0]         vel_q [WINDOW];
    logic                  ang_done;
    logic                  vel_done;
    logic signed [DW-1:0]  ang_slope;
    logic signed [DW-1:0]  vel_slope;

    assign accept   = in_valid && (state_reg == rtlsd_pkg::ST_IDLE);
    assign scanning = (state_reg == rtlsd_pkg::ST_SCAN);
    assign shift_en = accept || scanning;
    assign out_load = (state_reg == rtlsd_pkg::ST_WAIT) && ang_done && vel_done &&
                      (!out_valid_reg || !out_stall);

    always_comb
    begin
        ctl.clear  = accept;
        ctl.acc    = scanning;
        ctl.finish = scanning && (scan_reg == '0);
    end

    // Window chains: a push enters the newest sample at cell 0; a scan
    // rotates the tail back to cell 0, so after a full rotation the order is
    // restored. Cell k holds the sample of age k.
    for (genvar j = 0; j < WINDOW; j++)
    begin : g_chain
        logic [DW-1:0] ang_d;
        logic [DW-1:0] vel_d;
        if (j == 0)
        begin : g_head
            assign ang_d = accept ? last_angle_reg : ang_q[WINDOW-1];
            assign vel_d = accept ? last_vel_reg : vel_q[WINDOW-1];
        end
        else
        begin : g_body
            assign ang_d = ang_q[j-1];
            assign vel_d = vel_q[j-1];
        end

        rtlsd_cell #(
            .WIDTH(DW)
        ) u_ang_cell (
            .clk      (clk),
            .shift_en (shift_en),
            .d        (ang_d),
            .q        (ang_q[j])
        );

        rtlsd_cell #(
            .WIDTH(DW)
        ) u_vel_cell (
            .clk      (clk),
            .shift_en (shift_en),
            .d        (vel_d),
            .q        (vel_q[j])
        );
    end

    rtlsd_slope #(
        .WINDOW(WINDOW)
    ) u_ang_slope (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (ctl),
        .age    (scan_reg),
        .count  (fill_reg),
        .sample ($signed(ang_q[WINDOW-1])),
        .scale  (scale_reg),
        .done   (ang_done),
        .slope  (ang_slope)
    );

    rtlsd_slope #(
        .WINDOW(WINDOW)
    ) u_vel_slope (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (ctl),
        .age    (scan_reg),
        .count  (fill_reg),
        .sample ($signed(vel_q[WINDOW-1])),
        .scale  (scale_reg),
        .done   (vel_done),
        .slope  (vel_slope)
    );

    // Configuration registers.
    always_comb
    begin
        offset_next = offset_reg;
        span_next   = span_reg;
        scale_next  = scale_reg;
        if (cfg_wr_en)
        begin
            case (cfg_index)
                rtlsd_pkg::CFG_ANGLE_OFFSET: offset_next = $signed(cfg_data);
                rtlsd_pkg::CFG_ANGLE_SPAN:   span_next   = $signed(cfg_data);
                rtlsd_pkg::CFG_SLOPE_SCALE:  scale_next  = cfg_data[rtlsd_pkg::SCALE_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Control sequencer.
    always_comb
    begin
        state_next      = state_reg;
        fill_next       = fill_reg;
        scan_next       = scan_reg;
        last_angle_next = last_angle_reg;
        last_vel_next   = last_vel_reg;
        out_valid_next  = out_valid_reg && out_stall;
        out_angle_next  = out_angle_reg;
        out_vel_next    = out_vel_reg;
        out_acc_next    = out_acc_reg;

        case (state_reg)
            rtlsd_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (fill_reg < NW'(WINDOW))
                    begin
                        fill_next = fill_reg + 1'b1;
                    end
                    scan_next  = AGW'(WINDOW - 1);
                    state_next = rtlsd_pkg::ST_SCAN;
                end
            end
            rtlsd_pkg::ST_SCAN:
            begin
                scan_next = scan_reg - 1'b1;
                if (scan_reg == '0)
                begin
                    state_next = rtlsd_pkg::ST_WAIT;
                end
            end
            rtlsd_pkg::ST_WAIT:
            begin
                if (out_load)
                begin
                    out_angle_next  = hold_reg ? last_angle_reg : angle_calc_reg;
                    out_vel_next    = hold_reg ? '0 : ang_slope;
                    out_acc_next    = hold_reg ? '0 : vel_slope;
                    last_angle_next = hold_reg ? last_angle_reg : angle_calc_reg;
                    last_vel_next   = hold_reg ? '0 : ang_slope;
                    out_valid_next  = 1'b1;
                    state_next      = rtlsd_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = rtlsd_pkg::ST_IDLE;
            end
        endcase
    end

    // Angle path runs freely off the captured joystick word; it settles
    // long before the slopes are ready.
    always_comb
    begin
        joy_next        = accept ? joystick_y : joy_reg;
        hold_next       = accept ? hold : hold_reg;
        prod_next       = joy_reg * span_reg;
        rsum            = prod_reg + (prod_reg[PW-1] ? HALF - 1'b1 : HALF);
        rnd_next        = rsum[PW-1:rtlsd_pkg::JOY_FRAC];
        asum            = SUMW'(offset_reg) + SUMW'(rnd_reg);
        angle_calc_next = sat32(asum);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= rtlsd_pkg::ST_IDLE;
            offset_reg     <= rtlsd_pkg::ANGLE_OFFSET_RST;
            span_reg       <= rtlsd_pkg::ANGLE_SPAN_RST;
            scale_reg      <= rtlsd_pkg::SLOPE_SCALE_RST;
            fill_reg       <= '0;
            scan_reg       <= '0;
            last_angle_reg <= '0;
            last_vel_reg   <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            offset_reg     <= offset_next;
            span_reg       <= span_next;
            scale_reg      <= scale_next;
            fill_reg       <= fill_next;
            scan_reg       <= scan_next;
            last_angle_reg <= last_angle_next;
            last_vel_reg   <= last_vel_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        joy_reg        <= joy_next;
        hold_reg       <= hold_next;
        prod_reg       <= prod_next;
        rnd_reg        <= rnd_next;
        angle_calc_reg <= angle_calc_next;
        out_angle_reg  <= out_angle_next;
        out_vel_reg    <= out_vel_next;
        out_acc_reg    <= out_acc_next;
    end

    assign in_stall      = (state_reg != rtlsd_pkg::ST_IDLE);
    assign out_valid     = out_valid_reg;
    assign traj_angle    = out_angle_reg;
    assign traj_velocity = out_vel_reg;
    assign traj_accel    = out_acc_reg;

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= NW'(WINDOW))
        else $error("fill count above window depth");

    a_slopes_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
        ang_done == vel_done)
        else $error("slope units out of step");

    a_accept_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (state_reg == rtlsd_pkg::ST_SCAN) && !ang_done)
        else $error("accepted word did not start a scan");

    a_word_from_wait: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg == rtlsd_pkg::ST_WAIT))
        else $error("output word raised outside the wait state");

endmodule

[test/tb_reference_trajectory_ls_differentiator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_reference_trajectory_ls_differentiator
// Self-checking bench for the joystick trajectory differentiator. A queue of
// joystick words feeds a clocked driver, and a clocked monitor checks every
// output word against a built-in fixed-point model. The model covers the
// angle mapping, the two sliding windows and the least-squares slopes. The
// run steps through several register settings and through idle and stall
// patterns on both channels.
// ----------------------------------------------------------------------------
module tb_reference_trajectory_ls_differentiator;

    localparam int DATA_W     = rtlsd_pkg::DATA_W;
    localparam int JOY_W      = rtlsd_pkg::JOY_W;
    localparam int JOY_FRAC   = rtlsd_pkg::JOY_FRAC;
    localparam int SCALE_W    = rtlsd_pkg::SCALE_W;
    localparam int SCALE_FRAC = rtlsd_pkg::SCALE_FRAC;
    localparam int CFG_IDX_W  = rtlsd_pkg::CFG_IDX_W;
    localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_OFFSET = rtlsd_pkg::CFG_ANGLE_OFFSET;
    localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_SPAN   = rtlsd_pkg::CFG_ANGLE_SPAN;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOPE_SCALE  = rtlsd_pkg::CFG_SLOPE_SCALE;
    localparam logic signed [DATA_W-1:0] ANGLE_OFFSET_RST = rtlsd_pkg::ANGLE_OFFSET_RST;
    localparam logic signed [DATA_W-1:0] ANGLE_SPAN_RST   = rtlsd_pkg::ANGLE_SPAN_RST;
    localparam logic [SCALE_W-1:0]       SLOPE_SCALE_RST  = rtlsd_pkg::SLOPE_SCALE_RST;

    localparam int WIN          = rtlsd_pkg::WINDOW_DEFAULT;
    localparam int RANDOM_WORDS = 500;
    localparam int HOLDOFF_CYC  = 400;
    localparam int SETTLE_CYC   = WIN + 60;
    localparam int TIMEOUT_NS   = 30_000_000;
    localparam logic [CFG_IDX_W-1:0] CFG_NO_REG = 2'd3;
    localparam longint SCALE_ONE = longint'(1) << SCALE_FRAC;
    localparam longint JOY_ONE   = longint'(1) << JOY_FRAC;
    localparam longint SLOPE_LIM = longint'(1) << 33;

    typedef struct {
        logic signed [JOY_W-1:0] joy;
        logic                    hold;
    } stick_t;

    typedef struct {
        logic signed [DATA_W-1:0] angle;
        logic signed [DATA_W-1:0] vel;
        logic signed [DATA_W-1:0] acc;
    } traj_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_ANGLE_OFFSET;
    logic [DATA_W-1:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic signed [JOY_W-1:0] joystick_y = '0;
    logic hold = 1'b0;
    logic out_valid;
    logic out_stall = 1'b1;
    logic signed [DATA_W-1:0] traj_angle;
    logic signed [DATA_W-1:0] traj_velocity;
    logic signed [DATA_W-1:0] traj_accel;

    reference_trajectory_ls_differentiator DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .joystick_y    (joystick_y),
        .hold          (hold),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .traj_angle    (traj_angle),
        .traj_velocity (traj_velocity),
        .traj_accel    (traj_accel)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Model copy of the registers and of the differentiator state.
    logic signed [DATA_W-1:0] cfg_offset = ANGLE_OFFSET_RST;
    logic signed [DATA_W-1:0] cfg_span   = ANGLE_SPAN_RST;
    logic [SCALE_W-1:0]       cfg_scale  = SLOPE_SCALE_RST;
    logic signed [DATA_W-1:0] angle_hist [WIN];
    logic signed [DATA_W-1:0] vel_hist [WIN];
    int                       hist_fill  = 0;
    logic signed [DATA_W-1:0] prev_angle = '0;
    logic signed [DATA_W-1:0] prev_vel   = '0;

    stick_t joy_words [$];
    traj_t  expected_traj [$];
    stick_t cur_word;

    int  error_count     = 0;
    int  words_sent      = 0;
    int  holds_sent      = 0;
    int  results_checked = 0;
    int  settings_used   = 1;
    int  send_idle_pct   = 0;
    int  recv_stall_pct  = 0;
    bit  holdoff_start   = 1'b0;
    logic rx_holdoff     = 1'b0;

    task automatic report_error(input string msg);
        $display("ERROR at %0t: %s", $realtime, msg);
        error_count++;
    endtask

    // Division by a positive divisor, rounded to nearest, ties away from zero.
    function automatic longint div_round(input longint v, input longint d);
        longint mag;
        longint q;
        mag = (v < 0) ? -v : v;
        q = (mag + d / 2) / d;
        return (v < 0) ? -q : q;
    endfunction

    function automatic logic signed [DATA_W-1:0] clamp32(input longint v);
        if (v > longint'(32'sh7FFF_FFFF))
            return 32'sh7FFF_FFFF;
        if (v < -longint'(32'sh7FFF_FFFF) - 1)
            return 32'sh8000_0000;
        return v[DATA_W-1:0];
    endfunction

    // Least-squares slope over sample index 0..n-1, then scaled.
    function logic signed [DATA_W-1:0] ls_slope(input bit of_vel, input int n);
        longint sx;
        longint sxx;
        longint sy;
        longint sxy;
        longint y;
        longint num;
        longint den;
        longint slope;
        sx = 0;
        sxx = 0;
        sy = 0;
        sxy = 0;
        for (int i = 0; i < n; i++)
        begin
            y = of_vel ? longint'(vel_hist[i]) : longint'(angle_hist[i]);
            sx += i;
            sxx += i * i;
            sy += y;
            sxy += longint'(i) * y;
        end
        den = longint'(n) * sxx - sx * sx;
        if (den <= 0)
            return '0;
        num = longint'(n) * sxy - sx * sy;
        slope = div_round(num, den);
        if (slope > SLOPE_LIM)
            slope = SLOPE_LIM;
        if (slope < -SLOPE_LIM)
            slope = -SLOPE_LIM;
        return clamp32(div_round(slope * longint'(cfg_scale), SCALE_ONE));
    endfunction

    // Advances the model by one joystick word and returns the expected output.
    function traj_t step_trajectory(input stick_t w);
        traj_t r;
        if (hist_fill < WIN)
        begin
            angle_hist[hist_fill] = prev_angle;
            vel_hist[hist_fill] = prev_vel;
            hist_fill++;
        end
        else
        begin
            for (int i = 0; i < WIN - 1; i++)
            begin
                angle_hist[i] = angle_hist[i+1];
                vel_hist[i] = vel_hist[i+1];
            end
            angle_hist[WIN-1] = prev_angle;
            vel_hist[WIN-1] = prev_vel;
        end
        if (w.hold)
        begin
            r.angle = prev_angle;
            r.vel = '0;
            r.acc = '0;
        end
        else
        begin
            r.angle = clamp32(longint'(cfg_offset) +
                              div_round(longint'(w.joy) * longint'(cfg_span), JOY_ONE));
            r.vel = ls_slope(1'b0, hist_fill);
            r.acc = ls_slope(1'b1, hist_fill);
        end
        prev_angle = r.angle;
        prev_vel = r.vel;
        return r;
    endfunction

    always @(posedge clk)
    begin : driver
        stick_t nxt;
        traj_t  exp_word;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                exp_word = step_trajectory(cur_word);
                expected_traj.insert(expected_traj.size(), exp_word);
                words_sent++;
                if (cur_word.hold)
                    holds_sent++;
            end
            if (!in_valid || !in_stall)
            begin
                if (joy_words.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    nxt = joy_words[0];
                    joy_words.delete(0);
                    cur_word = nxt;
                    in_valid <= 1'b1;
                    joystick_y <= nxt.joy;
                    hold <= nxt.hold;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk)
    begin : monitor
        traj_t want;
        if (!rst_n)
        begin
            out_stall <= 1'b1;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_traj.size() == 0)
                begin
                    report_error("output word with nothing expected");
                end
                else
                begin
                    want = expected_traj[0];
                    expected_traj.delete(0);
                    results_checked++;
                    if (traj_angle !== want.angle)
                        report_error($sformatf("word %0d traj_angle got %0d want %0d",
                                               results_checked, traj_angle, want.angle));
                    if (traj_velocity !== want.vel)
                        report_error($sformatf("word %0d traj_velocity got %0d want %0d",
                                               results_checked, traj_velocity, want.vel));
                    if (traj_accel !== want.acc)
                        report_error($sformatf("word %0d traj_accel got %0d want %0d",
                                               results_checked, traj_accel, want.acc));
                end
            end
            out_stall <= rx_holdoff || ($urandom_range(99) < recv_stall_pct);
        end
    end

    // Long receiver hold-off so the output register fills and the input stalls.
    initial
    begin
        wait (holdoff_start);
        @(posedge clk);
        rx_holdoff <= 1'b1;
        repeat (HOLDOFF_CYC) @(posedge clk);
        rx_holdoff <= 1'b0;
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("Timeout: %0d words still expected", expected_traj.size());
        $display("DONE: errors detected");
        $finish;
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        case (idx)
            CFG_ANGLE_OFFSET: cfg_offset = data;
            CFG_ANGLE_SPAN:   cfg_span = data;
            CFG_SLOPE_SCALE:  cfg_scale = data[SCALE_W-1:0];
            default: ;
        endcase
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic load_settings(input logic [DATA_W-1:0] offset, input logic [DATA_W-1:0] span,
                                 input logic [DATA_W-1:0] scale_word);
        write_reg(CFG_ANGLE_OFFSET, offset);
        write_reg(CFG_ANGLE_SPAN, span);
        write_reg(CFG_SLOPE_SCALE, scale_word);
        settings_used++;
    endtask

    task automatic queue_word(input logic signed [JOY_W-1:0] joy, input logic hld);
        stick_t w;
        w.joy = joy;
        w.hold = hld;
        joy_words.insert(joy_words.size(), w);
    endtask

    task automatic drain_outputs();
        while (joy_words.size() != 0 || in_valid || expected_traj.size() != 0)
            @(posedge clk);
    endtask

    // Random words in segments: ramps and steady runs give meaningful slopes,
    // while noise, extremes and hold runs break the windows up.
    task automatic queue_random_words(input int count);
        int left;
        int len;
        int kind;
        logic signed [JOY_W-1:0] j;
        logic signed [JOY_W-1:0] step;
        left = count;
        while (left > 0)
        begin
            len = $urandom_range(1, 30);
            if (len > left)
                len = left;
            kind = $urandom_range(0, 9);
            j = 16'($urandom);
            step = $signed(16'($urandom_range(0, 4000))) - 16'sd2000;
            for (int k = 0; k < len; k++)
            begin
                case (kind)
                    0, 1, 2, 3: queue_word(16'(j + step * k), 1'b0);
                    4:          queue_word(j, 1'b0);
                    5, 6:       queue_word(16'($urandom), 1'b0);
                    7:          queue_word(($urandom_range(1)) ?
                                           (($urandom_range(1)) ? 16'sh7FFF : 16'sh8000) :
                                           (($urandom_range(1)) ? 16'sh0000 : 16'shFFFF),
                                           1'b0);
                    8:          queue_word(16'($urandom), 1'b1);
                    default:    queue_word(16'($urandom), ($urandom_range(99) < 30));
                endcase
            end
            left -= len;
        end
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset defaults: first word sees a one-sample window, then the
        // extremes, hold runs and enough words to fill and slide the windows.
        queue_word(16'sh0000, 1'b0);
        queue_word(16'sh7FFF, 1'b0);
        queue_word(16'sh8000, 1'b0);
        queue_word(16'sh7FFF, 1'b1);
        queue_word(16'sh8000, 1'b1);
        queue_word(16'shFFFF, 1'b0);
        queue_word(16'sh4000, 1'b0);
        for (int k = 0; k < 6; k++)
            queue_word(16'(k * 3000 - 9000), 1'b0);
        drain_outputs();

        // Saturating extremes, a scale above one and a write to the spare index.
        load_settings(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        write_reg(CFG_NO_REG, 32'hFFFF_FFFF);
        for (int k = 0; k < 3; k++)
        begin
            queue_word(16'sh7FFF, 1'b0);
            queue_word(16'sh8000, 1'b0);
        end
        queue_word(16'sh1234, 1'b1);
        queue_word(16'sh0000, 1'b0);
        drain_outputs();
        write_reg(CFG_ANGLE_OFFSET, 32'h8000_0000);
        queue_word(16'sh8000, 1'b0);
        queue_word(16'sh7FFF, 1'b0);
        queue_word(16'sh8000, 1'b0);
        drain_outputs();

        for (int p = 0; p < 4; p++)
        begin
            case (p)
                0:
                begin
                    load_settings($urandom, $urandom, $urandom_range(0, 1 << 24));
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    load_settings(32'h8000_0000, 32'h8000_0000, 32'h0);
                    send_idle_pct = 46;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    load_settings(ANGLE_OFFSET_RST, ANGLE_SPAN_RST, 32'(SCALE_ONE));
                    send_idle_pct = 0;
                    recv_stall_pct = 46;
                end
                default:
                begin
                    load_settings($urandom, $urandom, $urandom);
                    write_reg(CFG_NO_REG, $urandom);
                    send_idle_pct = 32;
                    recv_stall_pct = 32;
                end
            endcase
            queue_random_words(RANDOM_WORDS);
            if (p == 0)
                holdoff_start = 1'b1;
            drain_outputs();
        end

        repeat (SETTLE_CYC) @(posedge clk);
        if (expected_traj.size() != 0)
            report_error($sformatf("%0d output words never arrived", expected_traj.size()));
        $display("Covered %0d joystick words (%0d in hold) under %0d register settings,",
                 words_sent, holds_sent, settings_used);
        $display("from reset defaults to saturating extremes; %0d output words compared.",
                 results_checked);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
